FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FRC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frc assertion failed");
`define FRC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("frc assertion failed");
`else
`define FRC_ASSERT(lbl, clk, rst, prop)
`define FRC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Shared widths, codes and default sizes of the frame chunk reassembler.
// ----------------------------------------------------------------------------
package frc_pkg;

  localparam int DEF_FRAME_WIDTH  = 160;
  localparam int DEF_FRAME_HEIGHT = 120;
  localparam int DEF_CHUNK_SIZE   = 1024;
  localparam int DEF_MAX_CHUNKS   = 32;
  localparam int DEF_HDR_LEN      = 32;

  localparam int HDR_FIELDS = 30;
  localparam int RADDR_W    = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 2'd2;

  localparam logic FUNC_PACKET = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [1:0] ST_INVALID  = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;

endpackage

FILE: rtl/core/frc_if.sv
// ----------------------------------------------------------------------------
// frc_if
// Valid/ready channels for packet words in and result words out.
// ----------------------------------------------------------------------------
interface frc_pkt_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [7:0]                   data_byte;
  logic                         last_byte;
  logic [frc_pkg::RADDR_W-1:0]  read_address;

  modport source (output valid, func, data_byte, last_byte, read_address, input ready);
  modport sink   (input valid, func, data_byte, last_byte, read_address, output ready);
endinterface

interface frc_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [1:0] status;
  logic [7:0] read_data;

  modport source (output valid, result_kind, status, read_data, input ready);
  modport sink   (input valid, result_kind, status, read_data, output ready);
endinterface

FILE: rtl/core/frame_chunk_reassembler.sv
// ----------------------------------------------------------------------------
// frame_chunk_reassembler
// Parses chunked packets, validates the header, commits chunks to a frame and serves frame reads.
// ----------------------------------------------------------------------------
// channel  dir  words                                   result
// pkt      in   func, data_byte, last_byte, read_address one per last byte/read
// res      out  result_kind, status, read_data           via two-stage buffer
// cfg      in   cfg_wr_en, cfg_index, cfg_data           none
//
// One word per cycle while running and res does not stall; the read data is
// registered beside s1 and then in the output buffer. After a newly accepted
// chunk, pkt stalls while the staging memory is copied into the frame memory,
// one byte a cycle. After reset all FRAME_WIDTH*FRAME_HEIGHT frame bytes
// (19200 by default) are zeroed, with pkt held off; config writes are taken
// meanwhile. res backpressure stalls pkt once both result stages are full.
// ----------------------------------------------------------------------------
module frame_chunk_reassembler #(
  parameter int FRAME_WIDTH  = frc_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = frc_pkg::DEF_FRAME_HEIGHT,
  parameter int CHUNK_SIZE   = frc_pkg::DEF_CHUNK_SIZE,
  parameter int MAX_CHUNKS   = frc_pkg::DEF_MAX_CHUNKS,
  parameter int HDR_LEN      = frc_pkg::DEF_HDR_LEN
) (
  input  logic                            clk,
  input  logic                            rst,
  frc_pkt_if.sink                         pkt,
  frc_res_if.source                       res,
  input  logic                            cfg_wr_en,
  input  logic [frc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [frc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int FB      = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int FA_W    = (FB > 1) ? $clog2(FB) : 1;
  localparam int SA_W    = $clog2(CHUNK_SIZE);
  localparam int CL_W    = $clog2(CHUNK_SIZE + 1);
  localparam int TOT_W   = $clog2(FB + 1);
  localparam int EXP_CNT = (FB + CHUNK_SIZE - 1) / CHUNK_SIZE;

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'b001,
    MODE_RUN   = 3'b010,
    MODE_COPY  = 3'b100
  } mode_t;

  mode_t mode;

  // configuration
  logic [31:0] exp_magic;
  logic [7:0]  exp_version;
  logic [7:0]  exp_format;

  // packet state
  logic [15:0]      pos;
  logic [7:0]       hdr [frc_pkg::HDR_FIELDS];
  logic [31:0]      idx_prod;
  logic [31:0]      cur_fid;
  logic [31:0]      cur_ctime;
  logic             frame_open;
  logic [31:0]      chunks;
  logic [TOT_W-1:0] total;

  // memories
  logic [7:0] stg_mem [CHUNK_SIZE];
  logic [7:0] fs_mem  [FB];
  logic [7:0] stg_q;
  logic [7:0] rd_q;

  // clear and copy sequencing
  logic [FA_W-1:0] clr_cnt;
  logic [CL_W-1:0] cp_cnt;
  logic [CL_W-1:0] copy_len;
  logic [FA_W-1:0] copy_base;
  logic            wr_pend;
  logic [FA_W-1:0] wr_addr;

  // result stages
  logic       s1_valid, s1_kind, s1_inr;
  logic [1:0] s1_status;
  logic       ob_valid, ob_kind;
  logic [1:0] ob_status;
  logic [7:0] ob_data;

  logic            s1_move, acc, acc_pkt, acc_rd, acc_last, gives_res;
  logic [15:0]     pos_inc;
  logic [7:0]      hcur [frc_pkg::HDR_FIELDS];
  logic [31:0]     magic, fid, ctime, offset;
  logic [15:0]     hlen, wid, hei, idx, cnt, pay, exp_pay;
  logic            hdr_ok, fid_new, pkt_ok, dup, complete, cp_issue, inr;
  logic [31:0]     base_chunks, chunks_new, full;
  logic [TOT_W-1:0] base_total, total_new;
  logic [1:0]      status_now;
  logic [16:0]     spos;
  logic            stg_we;
  logic            fs_we;
  logic [FA_W-1:0] fs_waddr;
  logic [7:0]      fs_wdata;

  assign s1_move   = s1_valid && (!ob_valid || res.ready);
  assign pkt.ready = (mode == MODE_RUN) && (!s1_valid || s1_move);
  assign acc       = pkt.valid && pkt.ready;
  assign acc_pkt   = acc && (pkt.func == frc_pkg::FUNC_PACKET);
  assign acc_rd    = acc && (pkt.func == frc_pkg::FUNC_READ);
  assign acc_last  = acc_pkt && pkt.last_byte;
  assign gives_res = acc_rd || acc_last;
  assign pos_inc   = (pos == 16'hFFFF) ? pos : pos + 16'd1;
  assign inr       = {17'd0, pkt.read_address} < 32'(FB);

  // forward the byte in flight into the header view
  always_comb begin
    for (int k = 0; k < frc_pkg::HDR_FIELDS; k++) begin
      hcur[k] = (pos == 16'(k)) ? pkt.data_byte : hdr[k];
    end
  end

  assign magic  = {hcur[0], hcur[1], hcur[2], hcur[3]};
  assign hlen   = {hcur[6], hcur[7]};
  assign fid    = {hcur[8], hcur[9], hcur[10], hcur[11]};
  assign ctime  = {hcur[12], hcur[13], hcur[14], hcur[15]};
  assign wid    = {hcur[16], hcur[17]};
  assign hei    = {hcur[18], hcur[19]};
  assign idx    = {hcur[20], hcur[21]};
  assign cnt    = {hcur[22], hcur[23]};
  assign offset = {hcur[24], hcur[25], hcur[26], hcur[27]};
  assign pay    = {hcur[28], hcur[29]};

  assign exp_pay = (32'(idx) + 32'd1 == 32'(cnt)) ? (16'(FB) - idx_prod[15:0])
                                                  : 16'(CHUNK_SIZE);

  assign hdr_ok = (pos_inc >= 16'(HDR_LEN))
               && (magic == exp_magic) && (hcur[4] == exp_version)
               && (hcur[5] == exp_format)
               && (hlen == 16'(HDR_LEN))
               && ({1'b0, pos_inc} == 17'(hlen) + 17'(pay))
               && (wid == 16'(FRAME_WIDTH)) && (hei == 16'(FRAME_HEIGHT))
               && (cnt != 16'd0) && (cnt <= 16'(MAX_CHUNKS)) && (idx < cnt)
               && (32'(cnt) == 32'(EXP_CNT)) && (offset == idx_prod)
               && (pay == exp_pay)
               && ({1'b0, offset} + 33'(pay) <= 33'(FB));

  assign fid_new     = cur_fid != fid;
  assign pkt_ok      = hdr_ok && (fid_new || (frame_open && cur_ctime == ctime));
  assign base_chunks = fid_new ? 32'd0 : chunks;
  assign base_total  = fid_new ? '0 : total;
  assign dup         = base_chunks[idx[4:0]];
  assign chunks_new  = dup ? base_chunks : (base_chunks | (32'd1 << idx[4:0]));
  assign total_new   = dup ? base_total : (base_total + TOT_W'(pay));

  always_comb begin
    for (int k = 0; k < 32; k++) begin
      full[k] = 16'(k) < cnt;
    end
  end

  assign complete   = (chunks_new == full) && (total_new == TOT_W'(FB));
  assign status_now = !pkt_ok ? frc_pkg::ST_INVALID
                    : (complete ? frc_pkg::ST_COMPLETE : frc_pkg::ST_ACCEPTED);

  // staging memory: written by payload bytes, read by the copy sequencer
  assign spos   = 17'(pos) - 17'(HDR_LEN);
  assign stg_we = acc_pkt && (pos >= 16'(HDR_LEN)) && (spos < 17'(CHUNK_SIZE));

  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[spos[SA_W-1:0]] <= pkt.data_byte;
    end
    stg_q <= stg_mem[cp_cnt[SA_W-1:0]];
  end

  // frame memory: one write port (clear or copy), one read port
  assign fs_we    = (mode == MODE_CLEAR) || wr_pend;
  assign fs_waddr = (mode == MODE_CLEAR) ? clr_cnt : wr_addr;
  assign fs_wdata = (mode == MODE_CLEAR) ? 8'd0 : stg_q;
  assign cp_issue = (mode == MODE_COPY) && (cp_cnt != copy_len);

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    if (acc_rd) begin
      rd_q <= fs_mem[FA_W'(pkt.read_address)];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_pkt && pos < 16'(frc_pkg::HDR_FIELDS)) begin
      hdr[pos[4:0]] <= pkt.data_byte;
    end
    // idx bytes are settled once position 22 arrives
    if (acc_pkt && pos == 16'd22) begin
      idx_prod <= 32'({hdr[20], hdr[21]}) * 32'(CHUNK_SIZE);
    end
    if (acc_last && pkt_ok && !dup) begin
      copy_len  <= CL_W'(pay);
      copy_base <= FA_W'(offset);
    end
    wr_addr <= copy_base + FA_W'(cp_cnt);
    if (gives_res) begin
      s1_kind   <= acc_rd;
      s1_status <= acc_rd ? frc_pkg::ST_INVALID : status_now;
      s1_inr    <= inr;
    end
    if (s1_move) begin
      ob_kind   <= s1_kind;
      ob_status <= s1_status;
      ob_data   <= (s1_kind == frc_pkg::KIND_READ && s1_inr) ? rd_q : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_CLEAR;
      clr_cnt     <= '0;
      exp_magic   <= '0;
      exp_version <= '0;
      exp_format  <= '0;
      pos         <= '0;
      cur_fid     <= '0;
      cur_ctime   <= '0;
      frame_open  <= 1'b0;
      chunks      <= '0;
      total       <= '0;
      cp_cnt      <= '0;
      wr_pend     <= 1'b0;
      s1_valid    <= 1'b0;
      ob_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          frc_pkg::CFG_MAGIC:   exp_magic   <= cfg_data;
          frc_pkg::CFG_VERSION: exp_version <= cfg_data[7:0];
          frc_pkg::CFG_FORMAT:  exp_format  <= cfg_data[7:0];
          default: ;
        endcase
      end

      wr_pend <= cp_issue;

      case (mode)
        MODE_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == FA_W'(FB - 1)) begin
            mode <= MODE_RUN;
          end
        end
        MODE_RUN: begin
          if (acc_pkt) begin
            pos <= acc_last ? 16'd0 : pos_inc;
          end
          if (acc_last && pkt_ok) begin
            cur_fid    <= fid;
            cur_ctime  <= ctime;
            frame_open <= 1'b1;
            chunks     <= chunks_new;
            total      <= total_new;
            if (!dup) begin
              cp_cnt <= '0;
              mode   <= MODE_COPY;
            end
          end
        end
        MODE_COPY: begin
          if (cp_issue) begin
            cp_cnt <= cp_cnt + 1'b1;
          end else if (!wr_pend) begin
            mode <= MODE_RUN;
          end
        end
        default: mode <= MODE_RUN;
      endcase

      if (gives_res) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        ob_valid <= 1'b1;
      end else if (res.ready) begin
        ob_valid <= 1'b0;
      end
    end
  end

  assign res.valid       = ob_valid;
  assign res.result_kind = ob_kind;
  assign res.status      = ob_status;
  assign res.read_data   = ob_data;

`include "assert_macros.svh"

  `FRC_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> mode == MODE_CLEAR)
  `FRC_ASSERT(a_copy_nonempty, clk, rst, mode == MODE_COPY |-> copy_len != '0)
  `FRC_ASSERT(a_copy_in_frame, clk, rst, wr_pend |-> {1'b0, wr_addr} < (FA_W + 1)'(FB))
  `FRC_ASSERT(a_no_take_busy, clk, rst, mode != MODE_RUN |-> !pkt.ready)
  `FRC_ASSERT(a_s1_holds, clk, rst, s1_valid && !s1_move |=> s1_valid && $stable(s1_kind))

endmodule

FILE: sim/frame_chunk_reassembler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_chunk_reassembler_tb
// Drives chunked packets and frame reads through the reassembler and checks
// every status and read word against a behavioral copy of the frame store.
// ----------------------------------------------------------------------------
module frame_chunk_reassembler_tb;

  localparam int FRAME_SIZE  = 160 * 120;
  localparam int CHUNK_BYTES = 1024;
  localparam int HDR_BYTES   = 32;
  localparam int NUM_CHUNKS  = 19;
  localparam int COPY_WAIT   = 1100;
  localparam int CYCLE_LIMIT = 3000000;

  typedef bit [7:0] byte_q_t[$];

  typedef struct {
    bit [31:0] magic;
    bit [7:0]  ver;
    bit [7:0]  fmt;
    bit [15:0] hlen;
    bit [31:0] fid;
    bit [31:0] ctime;
    bit [15:0] wid;
    bit [15:0] hei;
    bit [15:0] idx;
    bit [15:0] cnt;
    bit [31:0] off;
    bit [15:0] pay;
  } chunk_hdr_t;

  class reassembly_checker;
    typedef struct {
      logic       kind;
      logic [1:0] status;
      logic [7:0] data;
    } result_t;

    result_t   pending_results[$];
    bit [31:0] magic_reg;
    bit [7:0]  version_reg;
    bit [7:0]  format_reg;
    bit [15:0] byte_count;
    bit [7:0]  hdr[frc_pkg::HDR_FIELDS];
    bit [7:0]  staging[CHUNK_BYTES];
    bit [31:0] open_fid;
    bit [31:0] cap_time;
    bit        open;
    bit [31:0] chunk_mask;
    int unsigned byte_total;
    bit [7:0]  pixels[FRAME_SIZE];
    int        mismatches;

    function bit [31:0] hdr_field(int at, int n);
      bit [31:0] v;
      v = 0;
      for (int i = 0; i < n; i++) v = (v << 8) | hdr[at + i];
      return v;
    endfunction

    function logic [1:0] settle_packet(int unsigned len);
      bit [31:0] fid, ct, idx, cnt, off, pay, exp_pay, mask_bit, full;
      if (len < HDR_BYTES) return frc_pkg::ST_INVALID;
      if (hdr_field(0, 4) != magic_reg || hdr[4] != version_reg || hdr[5] != format_reg)
        return frc_pkg::ST_INVALID;
      pay = hdr_field(28, 2);
      if (hdr_field(6, 2) != HDR_BYTES || len != HDR_BYTES + pay)
        return frc_pkg::ST_INVALID;
      if (hdr_field(16, 2) != 160 || hdr_field(18, 2) != 120) return frc_pkg::ST_INVALID;
      fid = hdr_field(8, 4);
      ct  = hdr_field(12, 4);
      idx = hdr_field(20, 2);
      cnt = hdr_field(22, 2);
      off = hdr_field(24, 4);
      if (cnt == 0 || cnt > 32 || idx >= cnt) return frc_pkg::ST_INVALID;
      exp_pay = (idx + 1 == cnt) ? ((FRAME_SIZE - idx * CHUNK_BYTES) & 32'hFFFF)
                                 : CHUNK_BYTES;
      if (cnt != NUM_CHUNKS || off != idx * CHUNK_BYTES || pay != exp_pay ||
          longint'(off) + pay > FRAME_SIZE)
        return frc_pkg::ST_INVALID;
      if (open_fid != fid) begin
        open_fid   = fid;
        cap_time   = ct;
        open       = 1'b1;
        chunk_mask = 0;
        byte_total = 0;
      end else if (!open || cap_time != ct) begin
        return frc_pkg::ST_INVALID;
      end
      mask_bit = 32'd1 << idx[4:0];
      if ((chunk_mask & mask_bit) == 0) begin
        for (int unsigned i = 0; i < pay && i < CHUNK_BYTES; i++)
          if (off + i < FRAME_SIZE) pixels[off + i] = staging[i];
        chunk_mask |= mask_bit;
        byte_total += pay;
      end
      full = (cnt == 32) ? 32'hFFFFFFFF : ((32'd1 << cnt) - 1);
      if (chunk_mask == full && byte_total == FRAME_SIZE) return frc_pkg::ST_COMPLETE;
      return frc_pkg::ST_ACCEPTED;
    endfunction

    function void take_word(logic f, logic [7:0] d, logic l, logic [14:0] a);
      result_t r;
      int unsigned pos;
      if (f == frc_pkg::FUNC_READ) begin
        r.kind   = frc_pkg::KIND_READ;
        r.status = frc_pkg::ST_INVALID;
        r.data   = (a < FRAME_SIZE) ? pixels[a] : 8'd0;
        pending_results.push_back(r);
        return;
      end
      pos = byte_count;
      if (pos < frc_pkg::HDR_FIELDS) hdr[pos] = d;
      if (pos >= HDR_BYTES && pos - HDR_BYTES < CHUNK_BYTES) staging[pos - HDR_BYTES] = d;
      if (pos < 65535) pos++;
      if (!l) begin
        byte_count = 16'(pos);
        return;
      end
      byte_count = 0;
      r.kind   = frc_pkg::KIND_STATUS;
      r.status = settle_packet(pos);
      r.data   = 8'd0;
      pending_results.push_back(r);
    endfunction

    function void compare_result(logic kind, logic [1:0] status, logic [7:0] data);
      result_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d status %0d data %0h", kind, status, data);
        return;
      end
      e = pending_results.pop_front();
      if (kind !== e.kind || status !== e.status || data !== e.data) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected kind %0d status %0d data %0h, got %0d %0d %0h",
                   e.kind, e.status, e.data, kind, status, data);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [frc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [frc_pkg::CFG_DATA_W-1:0] cfg_data;

  frc_pkt_if pkt();
  frc_res_if res();

  reassembly_checker rc = new();
  int send_idle;
  int recv_stall;
  int hold_off;
  int cycle_count;
  bit [31:0] cur_fid;

  frame_chunk_reassembler dut (
    .clk(clk), .rst(rst), .pkt(pkt), .res(res),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a counted hold-off on request
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        res.ready <= 1'b0;
        hold_off--;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      rc.compare_result(res.result_kind, res.status, res.read_data);
  end

  function automatic bit [31:0] ctime_of(bit [31:0] fid);
    return fid ^ 32'h5A5A1234;
  endfunction

  function automatic logic [14:0] pick_addr();
    if ($urandom_range(99) < 80) return 15'($urandom_range(FRAME_SIZE - 1));
    return 15'($urandom_range(32767));
  endfunction

  function automatic chunk_hdr_t good_hdr(bit [31:0] fid, int idx);
    chunk_hdr_t h;
    h.magic = rc.magic_reg;
    h.ver   = rc.version_reg;
    h.fmt   = rc.format_reg;
    h.hlen  = 16'(HDR_BYTES);
    h.fid   = fid;
    h.ctime = ctime_of(fid);
    h.wid   = 16'd160;
    h.hei   = 16'd120;
    h.idx   = 16'(idx);
    h.cnt   = 16'(NUM_CHUNKS);
    h.off   = 32'(idx * CHUNK_BYTES);
    h.pay   = 16'((idx == NUM_CHUNKS - 1) ? FRAME_SIZE - idx * CHUNK_BYTES : CHUNK_BYTES);
    return h;
  endfunction

  function automatic void put_be(ref byte_q_t q, input bit [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) q.push_back(v[i*8 +: 8]);
  endfunction

  task automatic send_word(logic f, logic [7:0] d, logic l, logic [14:0] a);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      pkt.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    pkt.valid        <= 1'b1;
    pkt.func         <= f;
    pkt.data_byte    <= d;
    pkt.last_byte    <= l;
    pkt.read_address <= a;
    do @(posedge clk); while (!pkt.ready);
    rc.take_word(f, d, l, a);
    @(negedge clk);
  endtask

  task automatic send_read(logic [14:0] a);
    send_word(frc_pkg::FUNC_READ, 8'($urandom), 1'($urandom), a);
  endtask

  task automatic send_packet(byte_q_t q, bit mix_reads);
    foreach (q[i]) begin
      if (mix_reads && $urandom_range(99) < 3) send_read(pick_addr());
      send_word(frc_pkg::FUNC_PACKET, q[i], i == q.size() - 1, 15'($urandom));
    end
  endtask

  // header, then payload_len random bytes
  task automatic send_chunk(chunk_hdr_t h, int payload_len, bit mix_reads);
    byte_q_t q;
    put_be(q, h.magic, 4);
    q.push_back(h.ver);
    q.push_back(h.fmt);
    put_be(q, h.hlen, 2);
    put_be(q, h.fid, 4);
    put_be(q, h.ctime, 4);
    put_be(q, h.wid, 2);
    put_be(q, h.hei, 2);
    put_be(q, h.idx, 2);
    put_be(q, h.cnt, 2);
    put_be(q, h.off, 4);
    put_be(q, h.pay, 2);
    put_be(q, $urandom, 2);
    repeat (payload_len) q.push_back(8'($urandom));
    send_packet(q, mix_reads);
  endtask

  task automatic send_noise(int len);
    byte_q_t q;
    repeat (len) q.push_back(8'($urandom));
    send_packet(q, 1'b1);
  endtask

  task automatic wait_drain();
    pkt.valid <= 1'b0;
    @(negedge clk);
    while (rc.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [frc_pkg::CFG_IDX_W-1:0] idx,
                           logic [frc_pkg::CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      frc_pkg::CFG_MAGIC:   rc.magic_reg   = v;
      frc_pkg::CFG_VERSION: rc.version_reg = v[7:0];
      frc_pkg::CFG_FORMAT:  rc.format_reg  = v[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(bit [31:0] m, bit [7:0] v, bit [7:0] f);
    wait_drain();
    repeat (COPY_WAIT) @(negedge clk);
    write_reg(frc_pkg::CFG_MAGIC, m);
    write_reg(frc_pkg::CFG_VERSION, {24'd0, v});
    write_reg(frc_pkg::CFG_FORMAT, {24'd0, f});
  endtask

  task automatic random_packet();
    chunk_hdr_t h;
    int r;
    int idx;
    r   = $urandom_range(99);
    idx = $urandom_range(NUM_CHUNKS - 1);
    if ($urandom_range(99) < 15) cur_fid = $urandom;
    h = good_hdr(cur_fid, idx);
    if (r < 60) begin
      if ($urandom_range(99) < 5) h.ctime = $urandom;
      send_chunk(h, h.pay, 1'b1);
    end else if (r < 75) begin
      h = good_hdr(cur_fid, NUM_CHUNKS - 1);
      case ($urandom_range(8))
        0: h.magic ^= 32'd1 << $urandom_range(31);
        1: h.ver   ^= 8'd1 << $urandom_range(7);
        2: h.fmt   ^= 8'd1 << $urandom_range(7);
        3: h.hlen  ^= 16'd1 << $urandom_range(15);
        4: h.wid   ^= 16'd1 << $urandom_range(15);
        5: h.hei   ^= 16'd1 << $urandom_range(15);
        6: h.cnt   ^= 16'd1 << $urandom_range(15);
        7: h.off   ^= 32'd1 << $urandom_range(31);
        default: h.idx ^= 16'd1 << $urandom_range(15);
      endcase
      send_chunk(h, h.pay, 1'b1);
    end else if (r < 90) begin
      send_noise($urandom_range(1, 40));
    end else begin
      send_chunk(h, ($urandom_range(1) != 0) ? h.pay + 1 : h.pay - 1, 1'b1);
    end
  endtask

  task automatic random_phase(int n_packets);
    repeat (n_packets) begin
      repeat ($urandom_range(0, 3)) send_read(pick_addr());
      random_packet();
    end
  endtask

  initial begin
    chunk_hdr_t h;
    int order[$];
    int tmp;
    int j;
    pkt.valid = 1'b0;
    pkt.func = frc_pkg::FUNC_PACKET;
    pkt.data_byte = 8'd0;
    pkt.last_byte = 1'b0;
    pkt.read_address = '0;
    cfg_wr_en = 1'b0;
    cfg_index = frc_pkg::CFG_MAGIC;
    cfg_data = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_off = 0;
    cur_fid = 32'h0000_0001;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // phase 0: no idling, directed cases, one full frame, backpressure
    set_config($urandom, 8'($urandom), 8'($urandom));
    send_read(15'd0);
    send_read(15'd19199);
    send_read(15'd19200);
    send_read(15'h7FFF);
    // frame id zero before any frame is open
    send_chunk(good_hdr(32'd0, NUM_CHUNKS - 1), 768, 1'b0);
    send_noise(1);
    send_noise(31);
    send_chunk(good_hdr(32'hA5A5_0001, NUM_CHUNKS - 1), 768, 1'b0);
    // duplicate with fresh content must leave the store alone
    send_chunk(good_hdr(32'hA5A5_0001, NUM_CHUNKS - 1), 768, 1'b1);
    send_read(15'd18432);
    send_read(15'd19199);
    h = good_hdr(32'hA5A5_0001, 0);
    h.ctime = ~h.ctime;
    send_chunk(h, h.pay, 1'b0);
    h = good_hdr(32'hA5A5_0001, 1);
    h.cnt = 16'd0;
    send_chunk(h, h.pay, 1'b0);
    h.cnt = 16'd33;
    send_chunk(h, h.pay, 1'b0);
    h = good_hdr(32'hA5A5_0001, 1);
    h.idx = 16'(NUM_CHUNKS);
    send_chunk(h, h.pay, 1'b0);
    h = good_hdr(32'hA5A5_0001, 2);
    h.pay = 16'd768;
    send_chunk(h, 768, 1'b0);
    // payload past the staging size
    h = good_hdr(32'hA5A5_0001, 3);
    send_chunk(h, CHUNK_BYTES + 6, 1'b0);
    // byte count saturates
    h = good_hdr(32'hA5A5_0001, 4);
    send_chunk(h, 65510, 1'b0);
    send_chunk(good_hdr(32'hA5A5_0001, 5), CHUNK_BYTES, 1'b0);

    // whole frame in shuffled order, then a duplicate reporting complete
    cur_fid = 32'h0BAD_F00D;
    for (int i = 0; i < NUM_CHUNKS; i++) order.push_back(i);
    for (int i = NUM_CHUNKS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      h = good_hdr(cur_fid, order[i]);
      send_chunk(h, h.pay, 1'b0);
    end
    h = good_hdr(cur_fid, order[0]);
    send_chunk(h, h.pay, 1'b0);

    // hold the result side off while reads pile up
    wait_drain();
    hold_off = 400;
    repeat (80) send_read(pick_addr());
    wait_drain();
    random_phase(25);

    set_config(32'd0, 8'd0, 8'd0);
    send_idle = 65;
    random_phase(25);

    set_config(32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send_idle = 0;
    recv_stall = 65;
    random_phase(25);

    set_config($urandom, 8'($urandom), 8'($urandom));
    send_idle = 35;
    recv_stall = 35;
    random_phase(25);

    wait_drain();
    repeat (COPY_WAIT) @(negedge clk);
    if (rc.mismatches == 0 && rc.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/frc_pkg.sv
rtl/core/frc_if.sv
rtl/core/frame_chunk_reassembler.sv
sim/frame_chunk_reassembler_tb.sv
